// ----- rtl/sbtc_pkg.sv -----
// Package for the seeded byte-table word cipher core.
// Holds the key rows, the per-lane operation codes and the command type
// passed from the front stage through the queue to the back stage.
package sbtc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] TYPE_XOR      = 8'd0;
    localparam logic [7:0] TYPE_SWAP     = 8'd1;
    localparam logic [7:0] TYPE_ADD      = 8'd2;
    localparam logic [7:0] TYPE_SUB      = 8'd3;
    localparam logic [7:0] TYPE_XOR_ADD  = 8'd4;
    localparam logic [7:0] TYPE_SUB_XOR  = 8'd5;
    localparam logic [7:0] TYPE_ROLLING  = 8'd6;
    localparam logic [7:0] TYPE_SEEDED   = 8'd7;

    localparam logic MODE_DECRYPT = 1'b0;
    localparam logic MODE_ENCRYPT = 1'b1;

    localparam logic [7:0] KEY_ROWS [4][32] = '{
        '{8'h00, 8'h1F, 8'h9B, 8'h69, 8'hA5, 8'h80, 8'h90, 8'hB2,
          8'hD7, 8'h44, 8'hEC, 8'h75, 8'h3B, 8'h62, 8'h0C, 8'hA3,
          8'hA6, 8'hE4, 8'h1F, 8'h4C, 8'h05, 8'hE4, 8'h44, 8'h6E,
          8'hD9, 8'h5B, 8'h34, 8'hE6, 8'h08, 8'h31, 8'h91, 8'h72},
        '{8'h00, 8'hAE, 8'hF3, 8'h7B, 8'h12, 8'hC9, 8'h83, 8'hF0,
          8'hA9, 8'h57, 8'h50, 8'h08, 8'h04, 8'h81, 8'h02, 8'h21,
          8'h96, 8'h09, 8'h0F, 8'h90, 8'hC3, 8'h62, 8'h27, 8'h21,
          8'h3B, 8'h22, 8'h4E, 8'h88, 8'hF5, 8'hC5, 8'h75, 8'h91},
        '{8'h00, 8'hE3, 8'hA2, 8'h45, 8'h40, 8'hE0, 8'h09, 8'hEA,
          8'h42, 8'h65, 8'h1C, 8'hC1, 8'hEB, 8'hB0, 8'h69, 8'h14,
          8'h01, 8'hD2, 8'h8E, 8'hFB, 8'hFA, 8'h86, 8'h09, 8'h95,
          8'h1B, 8'h61, 8'h14, 8'h0E, 8'h99, 8'h21, 8'hEC, 8'h40},
        '{8'h00, 8'h25, 8'h6D, 8'h4F, 8'hC5, 8'hCA, 8'h04, 8'h39,
          8'h3A, 8'h7D, 8'h0D, 8'hF1, 8'h43, 8'h05, 8'h71, 8'h66,
          8'h82, 8'h31, 8'h21, 8'hD8, 8'hFE, 8'h4D, 8'hC2, 8'hC8,
          8'hCC, 8'h09, 8'hA0, 8'h06, 8'h49, 8'hD5, 8'hF1, 8'h83}
    };

    typedef enum logic [3:0] {
        LOP_PASS,
        LOP_NOT,
        LOP_XOR,
        LOP_SWAP_XOR,
        LOP_XOR_SWAP,
        LOP_ADD,
        LOP_SUB,
        LOP_XOR_ADD,
        LOP_SUB_XOR
    } t_lane_op;

    // One classified word: the operation and key bytes of every lane.
    typedef struct packed {
        logic [31:0]          code;
        t_lane_op [3:0]       ops;
        logic [3:0][7:0]      ka;
        logic [3:0][7:0]      kb;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] key_byte(input logic [1:0] row, input logic [4:0] idx);
        return KEY_ROWS[row][idx];
    endfunction

endpackage

// ----- rtl/sbtc_front.sv -----
// Front stage: classifies an incoming word by type, mode and seed into one
// command with a lane operation and key bytes per lane. Uses sbtc_pkg.
module sbtc_front
    import sbtc_pkg::*;
(
    input  logic        i_mode,
    input  logic [31:0] i_code_word,
    input  logic [7:0]  i_cipher_type,
    input  logic [7:0]  i_seed_byte,
    output t_cmd        o_cmd
);

    // Primary key row for each lane, types zero through five.
    localparam logic [1:0] PA [6][4] = '{
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd1, 2'd3, 2'd2, 2'd0},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd1, 2'd3, 2'd0},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam logic [1:0] PB [4] = '{2'd0, 2'd3, 2'd2, 2'd1};

    logic [4:0] seed_idx;
    logic [7:0] eff_type;
    logic       enc;
    logic [2:0] type_idx;

    assign seed_idx = i_seed_byte[4:0];
    assign enc      = (i_mode == MODE_ENCRYPT);
    // An odd seed turns the seeded type into the nibble-swap type.
    assign eff_type = ((i_cipher_type == TYPE_SEEDED) && i_seed_byte[0]) ? TYPE_SWAP
                                                                         : i_cipher_type;
    assign type_idx = (eff_type <= TYPE_SUB_XOR) ? eff_type[2:0] : 3'd0;

    always_comb begin
        logic [1:0] rl;
        logic [4:0] ridx;
        o_cmd.code = i_code_word;
        for (int i = 0; i < 4; i++) begin
            rl   = 2'(3 - i);
            ridx = seed_idx + 5'(3 - i);
            o_cmd.ka[i] = key_byte(PA[type_idx][i], seed_idx);
            o_cmd.kb[i] = key_byte(PB[i], seed_idx);
            case (eff_type)
                TYPE_XOR: begin
                    o_cmd.ops[i] = LOP_XOR;
                end
                TYPE_SWAP: begin
                    o_cmd.ops[i] = enc ? LOP_XOR_SWAP : LOP_SWAP_XOR;
                end
                TYPE_ADD: begin
                    o_cmd.ops[i] = enc ? LOP_SUB : LOP_ADD;
                end
                TYPE_SUB: begin
                    o_cmd.ops[i] = enc ? LOP_ADD : LOP_SUB;
                end
                TYPE_XOR_ADD: begin
                    o_cmd.ops[i] = enc ? LOP_SUB_XOR : LOP_XOR_ADD;
                    o_cmd.kb[i]  = o_cmd.ka[i];
                end
                TYPE_SUB_XOR: begin
                    o_cmd.ops[i] = enc ? LOP_XOR_ADD : LOP_SUB_XOR;
                end
                TYPE_ROLLING: begin
                    o_cmd.ka[i] = key_byte(rl, ridx);
                    // Odd lanes add on decrypt, even lanes add on encrypt.
                    if ((i % 2) == 1) begin
                        o_cmd.ops[i] = enc ? LOP_SUB : LOP_ADD;
                    end else begin
                        o_cmd.ops[i] = enc ? LOP_ADD : LOP_SUB;
                    end
                end
                TYPE_SEEDED: begin
                    o_cmd.ops[i] = LOP_NOT;
                end
                default: begin
                    o_cmd.ops[i] = LOP_PASS;
                end
            endcase
        end
    end

endmodule

// ----- rtl/sbtc_queue.sv -----
// Short command queue between the front and back stages.
// Stores t_cmd entries from sbtc_pkg; depth is QUEUE_DEPTH.
module sbtc_queue
    import sbtc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_push_cmd,
    input  logic      i_pop,
    output t_cmd      o_pop_cmd,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push   = i_push && !o_status.full;
    assign do_pop    = i_pop && !o_status.empty;
    assign o_pop_cmd = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- rtl/sbtc_back.sv -----
// Back stage: applies the per-lane byte operations of one command and
// registers the result word with its strobe. Uses sbtc_pkg.
module sbtc_back
    import sbtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_result_valid,
    output logic [31:0] o_result_word
);

    logic [31:0] n_result_word;
    logic        r_result_valid;
    logic [31:0] r_result_word;

    always_comb begin
        logic [7:0] v;
        logic [7:0] ka;
        logic [7:0] kb;
        logic [7:0] t;
        for (int i = 0; i < 4; i++) begin
            v  = i_cmd.code[8*i +: 8];
            ka = i_cmd.ka[i];
            kb = i_cmd.kb[i];
            case (i_cmd.ops[i])
                LOP_PASS:     t = v;
                LOP_NOT:      t = ~v;
                LOP_XOR:      t = v ^ ka;
                LOP_SWAP_XOR: t = {v[3:0], v[7:4]} ^ ka;
                LOP_XOR_SWAP: begin
                    t = v ^ ka;
                    t = {t[3:0], t[7:4]};
                end
                LOP_ADD:      t = v + ka;
                LOP_SUB:      t = v - ka;
                LOP_XOR_ADD:  t = (v ^ ka) + kb;
                LOP_SUB_XOR:  t = (v - kb) ^ ka;
                default:      t = v;
            endcase
            n_result_word[8*i +: 8] = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid) begin
            r_result_word <= n_result_word;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result_word  = r_result_word;

endmodule

// ----- rtl/seeded_byte_table_word_cipher_core.sv -----
// Seeded byte-table word cipher core: front classifier, command queue, back lane unit.
// An accepted word is written into the queue, then its result is registered in the back
// lane unit and shown on o_result_word with o_valid for one cycle.
// Throughput: one word per cycle, set by the back lane unit that pops the queue
// whenever it is not empty. Reset (synchronous, active low) empties the queue and clears
// o_valid; the receiver cannot stall, so busy stays low in normal operation.
module seeded_byte_table_word_cipher_core
    import sbtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_code_word,
    input  logic [7:0]  i_cipher_type,
    input  logic [7:0]  i_seed_byte,
    output logic        o_valid,
    output logic [31:0] o_result_word
);

    t_cmd      front_cmd;
    t_cmd      queue_cmd;
    t_q_status q_status;
    logic      accept;
    logic      pop;

    assign busy   = q_status.full;
    assign accept = start && !busy;
    assign pop    = !q_status.empty;

    sbtc_front u_front (
        .i_mode        (i_mode),
        .i_code_word   (i_code_word),
        .i_cipher_type (i_cipher_type),
        .i_seed_byte   (i_seed_byte),
        .o_cmd         (front_cmd)
    );

    sbtc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_push_cmd (front_cmd),
        .i_pop      (pop),
        .o_pop_cmd  (queue_cmd),
        .o_status   (q_status)
    );

    sbtc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (pop),
        .i_cmd          (queue_cmd),
        .o_result_valid (o_valid),
        .o_result_word  (o_result_word)
    );

endmodule
